// ===== sv/acm_pkg.sv =====
`default_nettype none

package acm_pkg;

  // mode codes
  localparam logic [1:0] MODE_AM   = 2'd0;
  localparam logic [1:0] MODE_AMTC = 2'd1;
  localparam logic [1:0] MODE_FM   = 2'd2;
  localparam logic [1:0] MODE_PM   = 2'd3;

  // register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OPTION = 2'd2;

  localparam int MODE_BITS   = 2;
  localparam int STEP_BITS   = 32;
  localparam int OPTION_BITS = 21;
  localparam int OPTION_FRAC = 16;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF  = 32;
  localparam int TABLE_BITS_DEF  = 10;

  // pi/2 in q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // taylor series denominators (2n-1)*2n for the cosine terms
  localparam logic [63:0] TAYLOR_DIV [1:10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  // quarter-wave cosine entry k, cos(pi/2 * k / 2^table_bits) in q1.frac_bits
  function automatic logic [31:0] cos_entry(input int k, input int table_bits,
                                            input int frac_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (HALF_PI_Q30 * 64'(k)) >> table_bits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = sum + (longint'(1) << (29 - frac_bits));
    return 32'(sum >> (30 - frac_bits));
  endfunction

endpackage

`default_nettype wire

// ===== sv/analog_carrier_modulator_unit.sv =====
// AM / AM-with-carrier / FM / PM modulator around a carrier NCO. Each request
// on the slave stream carries one signed q1.(SAMPLE_BITS-1) message sample and
// a restart flag (tuser) that clears the carrier phase and the fm integral
// before that sample; each request gives one modulated sample, saturated to
// q2.(SAMPLE_BITS-1), with the clip flag in tuser of the master stream. The
// pipeline is six registers deep (input, gain multiply, phase accumulators,
// cosine table read, modulation multiply, output), and one sample is taken
// every clock as long as the master side keeps taking results; each stage
// holds its item when the one ahead is full, so bubbles are squeezed out.
// Both phase accumulators sit in a single stage and close their loop there,
// which is what sets the one-sample-per-clock rate. The cosine comes from a
// quarter-wave table of 2^TABLE_BITS+1 entries with a registered read, no
// interpolation. Registers (mode, carrier_step, option_value) are written
// through the cfg channel, which is always ready; write them only while no
// sample is in flight.
`default_nettype none

module analog_carrier_modulator_unit #(
  parameter int SAMPLE_BITS = acm_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = acm_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS  = acm_pkg::TABLE_BITS_DEF,
  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 8) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave stream: one message sample per request
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [IN_TDATA_BITS-1:0]           s_axis_tdata,  // sample
  input  wire logic                               s_axis_tuser,  // restart
  // master stream: one modulated sample per request
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0]               m_axis_tdata,  // modulated
  output logic                                    m_axis_tuser,  // clipped
  // register write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [acm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [acm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int FRAC_BITS = SAMPLE_BITS - 1;
  localparam int OUT_BITS  = SAMPLE_BITS + 1;
  localparam int TABLE_N   = 1 << TABLE_BITS;
  localparam int ADDR_BITS = TABLE_BITS + 1;

  // gain * x carries OPTION_FRAC + FRAC_BITS fraction bits of a turn
  localparam int GAIN_BITS = acm_pkg::OPTION_BITS + SAMPLE_BITS;
  localparam int GAIN_SH   = PHASE_BITS - (acm_pkg::OPTION_FRAC + FRAC_BITS);
  localparam int GAIN_SHL  = (GAIN_SH > 0) ? GAIN_SH : 0;
  localparam int GAIN_SHR  = (GAIN_SH < 0) ? -GAIN_SH : 0;
  localparam int WIDE_BITS = GAIN_BITS + PHASE_BITS;

  // amdsb-tc offset from q5.16 to q.FRAC_BITS
  localparam int OFF_SHL = (FRAC_BITS > acm_pkg::OPTION_FRAC) ?
                           FRAC_BITS - acm_pkg::OPTION_FRAC : 0;
  localparam int OFF_SHR = (FRAC_BITS < acm_pkg::OPTION_FRAC) ?
                           acm_pkg::OPTION_FRAC - FRAC_BITS : 0;
  localparam int OFF_RND = (1 << OFF_SHR) >> 1;
  localparam int D_BITS  = acm_pkg::OPTION_BITS + OFF_SHL + 2;

  localparam int P_BITS = D_BITS + OUT_BITS;
  localparam int Y_BITS = P_BITS + 1 - FRAC_BITS;

  localparam int NSTAGE = 6;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  logic [acm_pkg::MODE_BITS-1:0]          mode;
  logic [acm_pkg::STEP_BITS-1:0]          carrier_step;
  logic signed [acm_pkg::OPTION_BITS-1:0] option_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= acm_pkg::MODE_AM;
      carrier_step <= '0;
      option_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        acm_pkg::CFG_MODE:   mode         <= cfg_data[acm_pkg::MODE_BITS-1:0];
        acm_pkg::CFG_STEP:   carrier_step <= cfg_data[acm_pkg::STEP_BITS-1:0];
        acm_pkg::CFG_OPTION: option_value <= cfg_data[acm_pkg::OPTION_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic am_mode;
  assign am_mode = (mode == acm_pkg::MODE_AM) || (mode == acm_pkg::MODE_AMTC);

  // ---------------------------------------------------------------------------
  // stage occupancy: stage k loads when it is empty or the stage ahead loads
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] free;

  always_comb begin
    free[NSTAGE-1] = !v[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      free[k] = !v[k] || free[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (free[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_axis_tready = free[0];

  // ---------------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] x0;
  logic                          restart0;

  always_ff @(posedge clk) begin
    if (free[0]) begin
      x0       <= s_axis_tdata[SAMPLE_BITS-1:0];
      restart0 <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: gain product as a phase, am difference term
  // ---------------------------------------------------------------------------
  logic signed [GAIN_BITS-1:0] gain_prod;
  logic signed [WIDE_BITS-1:0] gain_wide;
  logic signed [WIDE_BITS-1:0] gain_shifted;
  logic signed [D_BITS-1:0]    opt_ext;
  logic signed [D_BITS-1:0]    offset;
  logic signed [D_BITS-1:0]    d_next;

  always_comb begin
    gain_prod    = option_value * x0;
    gain_wide    = WIDE_BITS'(gain_prod);
    // negative products wrap modulo one turn; a short phase floors the product
    gain_shifted = (gain_wide <<< GAIN_SHL) >>> GAIN_SHR;

    opt_ext = D_BITS'(option_value);
    offset  = ((opt_ext + D_BITS'(OFF_RND)) >>> OFF_SHR) <<< OFF_SHL;
    if (mode == acm_pkg::MODE_AMTC) begin
      d_next = D_BITS'(x0) - offset;
    end else begin
      d_next = D_BITS'(x0);
    end
  end

  logic [PHASE_BITS-1:0]    gphase1;
  logic signed [D_BITS-1:0] d1;
  logic                     restart1;

  always_ff @(posedge clk) begin
    if (free[1]) begin
      gphase1  <= gain_shifted[PHASE_BITS-1:0];
      d1       <= d_next;
      restart1 <= restart0;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: carrier and fm phase accumulators, table address
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] carrier_phase;
  logic [PHASE_BITS-1:0] message_phase;
  logic [PHASE_BITS-1:0] cp_cur;
  logic [PHASE_BITS-1:0] mp_cur;
  logic [PHASE_BITS-1:0] mp_fm;
  logic [PHASE_BITS-1:0] lookup_phase;
  logic [PHASE_BITS-1:0] step_ext;
  logic [1:0]            quadrant;
  logic [TABLE_BITS-1:0] tab_idx;
  logic [ADDR_BITS-1:0]  addr_next;
  logic                  phase_load;

  assign phase_load = v[1] && free[2];

  always_comb begin
    step_ext = PHASE_BITS'(carrier_step);
    cp_cur   = restart1 ? '0 : carrier_phase;
    mp_cur   = restart1 ? '0 : message_phase;
    mp_fm    = mp_cur + gphase1;
    case (mode)
      acm_pkg::MODE_FM: lookup_phase = cp_cur + mp_fm;
      acm_pkg::MODE_PM: lookup_phase = cp_cur + gphase1;
      default:          lookup_phase = cp_cur;
    endcase
    quadrant = lookup_phase[PHASE_BITS-1 -: 2];
    tab_idx  = lookup_phase[PHASE_BITS-3 -: TABLE_BITS];
    // odd quadrants walk the quarter wave backwards
    if (quadrant[0]) begin
      addr_next = ADDR_BITS'(TABLE_N) - {1'b0, tab_idx};
    end else begin
      addr_next = {1'b0, tab_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
      message_phase <= '0;
    end else if (phase_load) begin
      carrier_phase <= cp_cur + step_ext;
      // the integral only moves in fm
      if (mode == acm_pkg::MODE_FM) begin
        message_phase <= mp_fm;
      end else begin
        message_phase <= mp_cur;
      end
    end
  end

  logic [ADDR_BITS-1:0]     addr2;
  logic                     neg2;
  logic signed [D_BITS-1:0] d2;

  always_ff @(posedge clk) begin
    if (free[2]) begin
      addr2 <= addr_next;
      neg2  <= quadrant[1] ^ quadrant[0];
      d2    <= d1;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: quarter-wave cosine table, registered read
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] cos_rom [TABLE_N+1];

  for (genvar k = 0; k <= TABLE_N; k++) begin : g_rom
    assign cos_rom[k] = SAMPLE_BITS'(acm_pkg::cos_entry(k, TABLE_BITS, FRAC_BITS));
  end

  logic [SAMPLE_BITS-1:0]   mag3;
  logic                     neg3;
  logic signed [D_BITS-1:0] d3;

  always_ff @(posedge clk) begin
    if (free[3]) begin
      mag3 <= cos_rom[addr2];
      neg3 <= neg2;
      d3   <= d2;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: signed cosine and am product
  // ---------------------------------------------------------------------------
  logic signed [OUT_BITS-1:0] mag_ext;
  logic signed [OUT_BITS-1:0] cos_next;
  logic signed [P_BITS-1:0]   prod_next;

  always_comb begin
    mag_ext   = {1'b0, mag3};
    cos_next  = neg3 ? -mag_ext : mag_ext;
    prod_next = d3 * cos_next;
  end

  logic signed [OUT_BITS-1:0] cosv4;
  logic signed [P_BITS-1:0]   prod4;

  always_ff @(posedge clk) begin
    if (free[4]) begin
      cosv4 <= cos_next;
      prod4 <= prod_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: round half up, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [P_BITS:0]               rsum;
  logic signed [Y_BITS-1:0]             y_full;
  logic [Y_BITS-1-SAMPLE_BITS:0]        y_upper;
  logic                                 y_fits;
  logic [OUT_BITS-1:0]                  mod_next;
  logic                                 clip_next;

  always_comb begin
    rsum    = (P_BITS + 1)'(prod4) + (P_BITS + 1)'(1 << (FRAC_BITS - 1));
    y_full  = Y_BITS'(rsum >>> FRAC_BITS);
    y_upper = y_full[Y_BITS-1:SAMPLE_BITS];
    y_fits  = (y_upper == '0) || (y_upper == '1);
    if (!am_mode) begin
      mod_next  = cosv4;
      clip_next = 1'b0;
    end else if (y_fits) begin
      mod_next  = y_full[OUT_BITS-1:0];
      clip_next = 1'b0;
    end else begin
      // clamp to the end of the field on the side of the sign
      mod_next  = {y_full[Y_BITS-1], {SAMPLE_BITS{!y_full[Y_BITS-1]}}};
      clip_next = 1'b1;
    end
  end

  logic [OUT_BITS-1:0] out_mod;
  logic                out_clip;

  always_ff @(posedge clk) begin
    if (free[5]) begin
      out_mod  <= mod_next;
      out_clip <= clip_next;
    end
  end

  assign m_axis_tvalid = v[NSTAGE-1];
  assign m_axis_tdata  = OUT_TDATA_BITS'(out_mod);
  assign m_axis_tuser  = out_clip;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // clipping only happens in the am modes
  a_clip_am_only: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> am_mode)
    else $error("clip flag set outside am modes");

  // angle modes give a plain cosine, never beyond +-1.0
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !am_mode) |->
      ($signed(out_mod) <= $signed(OUT_BITS'(1 << FRAC_BITS)) &&
       $signed(out_mod) >= -$signed(OUT_BITS'(1 << FRAC_BITS))))
    else $error("angle mode output beyond unit amplitude");

  // a restart sample leaves the carrier exactly one step from zero
  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    (phase_load && restart1) |=> (carrier_phase == $past(step_ext)))
    else $error("carrier phase not cleared on restart");

  // an empty output register means the whole pipe can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // block widths at the default parameters
  localparam int SAMPLE_W    = 16;
  localparam int MOD_W       = SAMPLE_W + 1;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;
  localparam int QUARTER_N   = 1024;
  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_AFTER  = 600;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [MOD_W-1:0] modulated;
    logic             clipped;
  } mod_out_t;

  // dut ports
  logic                               clk;
  logic                               rst;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [IN_DATA_W-1:0]               s_axis_tdata;   // sample
  logic                               s_axis_tuser;   // restart
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [OUT_DATA_W-1:0]              m_axis_tdata;   // modulated (17 bits), zero pad
  logic                               m_axis_tuser;   // clipped
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [acm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [acm_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  // shadow copy of the registers and the two accumulators
  logic [1:0]         cur_mode;
  logic [31:0]        cur_step;
  logic signed [20:0] cur_gain;
  logic [31:0]        car_ph;
  logic [31:0]        msg_ph;

  int       cos_quarter [0:QUARTER_N];
  mod_out_t pending_mod [$];
  int       mismatches;
  int       sent_count;
  int       cycles;
  bit       quiet;          // no idling on either side in the last part
  int       hold_asked;     // long receiver hold-offs requested by a test
  int       hold_served;

  analog_carrier_modulator_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // quarter-wave cosine in q1.15: taylor series on pi/2 * k / 1024 in q2.30,
  // eleven terms, then rounded half up to 15 fraction bits
  task automatic fill_cos_quarter();
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    longint      acc;
    for (int k = 0; k <= QUARTER_N; k++) begin
      ang  = (acm_pkg::HALF_PI_Q30 * 64'(k)) >> 10;
      ang2 = (ang * ang) >> 30;
      term = 64'd1 << 30;
      acc  = longint'(term);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = acc + (longint'(1) << 14);
      cos_quarter[k] = int'(acc >>> 15);
    end
  endtask

  // table lookup on the top 2 quadrant bits and the next 10 index bits
  function automatic longint carrier_cos(input logic [31:0] ph);
    int idx;
    idx = int'(ph[29:20]);
    case (ph[31:30])
      2'd0:    return longint'(cos_quarter[idx]);
      2'd1:    return -longint'(cos_quarter[QUARTER_N - idx]);
      2'd2:    return -longint'(cos_quarter[idx]);
      default: return longint'(cos_quarter[QUARTER_N - idx]);
    endcase
  endfunction

  // expected output for one accepted sample; advances the shadow accumulators
  function automatic mod_out_t nco_modulate(input logic signed [15:0] x,
                                            input logic restart);
    longint      xs;
    longint      off;
    longint      d;
    longint      y;
    logic [31:0] gain_ph;
    mod_out_t    r;
    xs = longint'(x);
    r.clipped = 1'b0;
    if (restart) begin
      car_ph = '0;
      msg_ph = '0;
    end
    // gain (q5.16) times x (q1.15) is 31 fraction bits of a turn, phase is 32
    gain_ph = 32'((longint'(cur_gain) * xs) <<< 1);
    case (cur_mode)
      acm_pkg::MODE_AM, acm_pkg::MODE_AMTC: begin
        d = xs;
        if (cur_mode == acm_pkg::MODE_AMTC) begin
          // offset q5.16 rounded half up to q.15
          off = (longint'(cur_gain) + 1) >>> 1;
          d   = xs - off;
        end
        y = (d * carrier_cos(car_ph) + 16384) >>> 15;
        if (y > 65535) begin
          y = 65535;
          r.clipped = 1'b1;
        end
        if (y < -65536) begin
          y = -65536;
          r.clipped = 1'b1;
        end
      end
      acm_pkg::MODE_FM: begin
        msg_ph = msg_ph + gain_ph;
        y = carrier_cos(car_ph + msg_ph);
      end
      default: begin
        y = carrier_cos(car_ph + gain_ph);
      end
    endcase
    car_ph = car_ph + cur_step;
    r.modulated = y[MOD_W-1:0];
    return r;
  endfunction

  // one sample request; may idle a short burst before offering it
  task automatic send_sample(input logic [15:0] x, input logic restart);
    int       gap;
    mod_out_t exp_res;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = x;
    s_axis_tuser  = restart;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    exp_res     = nco_modulate(x, restart);
    pending_mod = {pending_mod, exp_res};
    sent_count++;
  endtask

  // stop offering and wait until every result is back, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_mod.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [acm_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      acm_pkg::CFG_MODE:   cur_mode = val[1:0];
      acm_pkg::CFG_STEP:   cur_step = val;
      acm_pkg::CFG_OPTION: cur_gain = val[20:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [20:0] pick_option();
    case ($urandom_range(0, 9))
      0:       return 21'h100000;
      1:       return 21'h0fffff;
      2:       return 21'h000000;
      3, 4, 5: return 21'($signed($urandom_range(0, 32767)) - 16384);
      default: return 21'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side: random short stalls, plus a long hold when a test asks
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int burst;
    int hold_left;
    burst = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 3) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    mod_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_mod.size() == 0) begin
        $display("%0t: result with none expected: tdata=%h tuser=%b", $time,
                 m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_mod.pop_front();
        if (m_axis_tdata !== OUT_DATA_W'(want.modulated)) begin
          $display("%0t: modulated mismatch: expected %h actual %h", $time,
                   OUT_DATA_W'(want.modulated), m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== want.clipped) begin
          $display("%0t: clipped mismatch: expected %b actual %b", $time,
                   want.clipped, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run limit reached", $time);
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: step 0 and cosine 1.0, so output equals the sample
  task automatic test_reset_defaults();
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b0);
    drain();
  endtask

  // quarter-turn carrier walks through all four quadrants
  task automatic test_am_quadrants();
    write_reg(acm_pkg::CFG_MODE, 32'(acm_pkg::MODE_AM));
    write_reg(acm_pkg::CFG_STEP, 32'h4000_0000);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h4001, 1'b0);
    drain();
  endtask

  // carrier offset at both extremes drives the output into saturation
  task automatic test_amtc_saturation();
    write_reg(acm_pkg::CFG_MODE, 32'hffff_fffd);      // upper bits ignored, mode amdsb-tc
    write_reg(acm_pkg::CFG_STEP, 32'hffff_ffff);
    write_reg(acm_pkg::CFG_OPTION, 32'h000f_ffff);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    drain();
    write_reg(acm_pkg::CFG_OPTION, 32'hfff0_0000);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0001, 1'b0);
    drain();
  endtask

  // fm: negative products wrap, and a new gain only affects later samples
  task automatic test_fm_integral();
    write_reg(acm_pkg::CFG_MODE, 32'(acm_pkg::MODE_FM));
    write_reg(acm_pkg::CFG_STEP, 32'h0123_4567);
    write_reg(acm_pkg::CFG_OPTION, 32'h0010_0000);    // most negative gain
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hffff, 1'b0);
    drain();
    write_reg(acm_pkg::CFG_OPTION, 32'h0000_4000);    // mid-stream gain change, no restart
    send_sample(16'h2000, 1'b0);
    send_sample(16'h2000, 1'b0);
    drain();
  endtask

  // fm integral holds while another mode runs, then continues
  task automatic test_integral_hold();
    write_reg(acm_pkg::CFG_MODE, 32'(acm_pkg::MODE_AM));
    send_sample(16'h1234, 1'b0);
    drain();
    write_reg(acm_pkg::CFG_MODE, 32'(acm_pkg::MODE_FM));
    send_sample(16'h0100, 1'b0);
    drain();
  endtask

  // pm with the largest gain, and the unused register index
  task automatic test_pm_extremes();
    write_reg(acm_pkg::CFG_MODE, 32'(acm_pkg::MODE_PM));
    write_reg(acm_pkg::CFG_OPTION, 32'h000f_ffff);
    write_reg(acm_pkg::CFG_INDEX_BITS'(3), 32'hdead_beef);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    drain();
  endtask

  // receiver holds off while samples keep coming, so the pipe fills and stalls
  task automatic test_backpressure();
    write_reg(acm_pkg::CFG_MODE, 32'(acm_pkg::MODE_AMTC));
    write_reg(acm_pkg::CFG_STEP, 32'h0765_4321);
    write_reg(acm_pkg::CFG_OPTION, 32'h0000_8000);
    send_sample(pick_sample(), 1'b1);
    hold_asked++;
    for (int i = 0; i < 30; i++) begin
      send_sample(pick_sample(), 1'(i == 12));
    end
    drain();
  endtask

  // random settings per phase, random samples with occasional restarts
  task automatic test_random_stream();
    int target;
    int n_items;
    bit wrote;
    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      if (sent_count >= target - (RANDOM_ITEMS - QUIET_AFTER)) begin
        quiet = 1'b1;
      end
      wrote = 1'b0;
      if ($urandom_range(0, 2) != 0) begin
        write_reg(acm_pkg::CFG_MODE, {30'($urandom()), 2'($urandom_range(0, 3))});
        wrote = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(acm_pkg::CFG_STEP, pick_step());
        wrote = 1'b1;
      end
      if ($urandom_range(0, 2) != 0 || !wrote) begin
        write_reg(acm_pkg::CFG_OPTION, {11'($urandom()), pick_option()});
      end
      n_items = $urandom_range(20, 80);
      for (int i = 0; i < n_items; i++) begin
        if (i == 0) begin
          send_sample(pick_sample(), 1'($urandom_range(0, 1)));
        end else begin
          send_sample(pick_sample(), 1'($urandom_range(0, 31) == 0));
        end
      end
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cur_mode      = acm_pkg::MODE_AM;
    cur_step      = '0;
    cur_gain      = '0;
    car_ph        = '0;
    msg_ph        = '0;
    mismatches    = 0;
    sent_count    = 0;
    quiet         = 1'b0;
    hold_asked    = 0;
    hold_served   = 0;
    fill_cos_quarter();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_am_quadrants();
    test_amtc_saturation();
    test_fm_integral();
    test_integral_hold();
    test_pm_extremes();
    test_backpressure();
    test_random_stream();

    drain();
    if (mismatches == 0 && pending_mod.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/acm_pkg.sv
sv/analog_carrier_modulator_unit.sv
bench/tb_top.sv
